/* design/wfht_pkg.sv */
package wfht_pkg;

    typedef enum logic [3:0] {
        HIT_NOWHERE     = 4'd0,
        HIT_CLIENT      = 4'd1,
        HIT_CAPTION     = 4'd2,
        HIT_LEFT        = 4'd3,
        HIT_RIGHT       = 4'd4,
        HIT_TOP         = 4'd5,
        HIT_TOPLEFT     = 4'd6,
        HIT_TOPRIGHT    = 4'd7,
        HIT_BOTTOM      = 4'd8,
        HIT_BOTTOMLEFT  = 4'd9,
        HIT_BOTTOMRIGHT = 4'd10,
        HIT_BORDER      = 4'd11
    } hit_t;

    typedef enum logic [1:0] {
        REG_RESIZE_X = 2'd0,
        REG_RESIZE_Y = 2'd1,
        REG_CORNER_X = 2'd2,
        REG_CORNER_Y = 2'd3
    } cfg_reg_t;

    localparam int FLAG_CAPTION    = 0;
    localparam int FLAG_FIXED      = 1;
    localparam int FLAG_RSZ_LEFT   = 2;
    localparam int FLAG_RSZ_TOP    = 3;
    localparam int FLAG_RSZ_RIGHT  = 4;
    localparam int FLAG_RSZ_BOTTOM = 5;
    localparam int FLAG_LEFT_ZERO  = 6;

    localparam logic [7:0] RESIZE_MARGIN_RST = 8'd10;
    localparam logic [7:0] CORNER_EXTENT_RST = 8'd17;

    typedef struct packed {
        logic [7:0] resize_x;
        logic [7:0] resize_y;
        logic [7:0] corner_x;
        logic [7:0] corner_y;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [11:0]        m_left;
        logic [11:0]        m_right;
        logic [11:0]        m_top;
        logic [11:0]        m_bottom;
        logic [6:0]         flags;
    } query_t;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } side_set_t;

    typedef struct packed {
        logic      in_rect;
        side_set_t grid;
        side_set_t rsz;
        side_set_t crn;
    } edge_hits_t;

    // p <= e + m
    function automatic logic at_or_before(logic signed [15:0] p, logic signed [15:0] e,
                                          logic [11:0] m);
        logic signed [17:0] lim;
        logic signed [17:0] pw;
        lim = $signed({{2{e[15]}}, e}) + $signed({6'd0, m});
        pw  = $signed({{2{p[15]}}, p});
        return pw <= lim;
    endfunction

    // p >= e - m
    function automatic logic at_or_after(logic signed [15:0] p, logic signed [15:0] e,
                                         logic [11:0] m);
        logic signed [17:0] lim;
        logic signed [17:0] pw;
        lim = $signed({{2{e[15]}}, e}) - $signed({6'd0, m});
        pw  = $signed({{2{p[15]}}, p});
        return pw >= lim;
    endfunction

endpackage

/* design/wfht_edges.sv */
module wfht_edges
(
    input  wfht_pkg::query_t     q,
    input  wfht_pkg::cfg_t       cfg,
    output wfht_pkg::edge_hits_t eh
);

    logic [11:0] rx;
    logic [11:0] ry;
    logic [11:0] cx;
    logic [11:0] cy;

    assign rx = {4'd0, cfg.resize_x};
    assign ry = {4'd0, cfg.resize_y};
    assign cx = {4'd0, cfg.corner_x};
    assign cy = {4'd0, cfg.corner_y};

    always_comb
    begin
        eh.in_rect = (q.x >= q.left) && (q.x < q.right) && (q.y >= q.top) && (q.y < q.bottom);

        eh.grid.left   = wfht_pkg::at_or_before(q.x, q.left, q.m_left);
        eh.grid.right  = wfht_pkg::at_or_after(q.x, q.right, q.m_right);
        eh.grid.top    = wfht_pkg::at_or_before(q.y, q.top, q.m_top);
        eh.grid.bottom = wfht_pkg::at_or_after(q.y, q.bottom, q.m_bottom);

        eh.rsz.left    = wfht_pkg::at_or_before(q.x, q.left, rx);
        eh.rsz.right   = wfht_pkg::at_or_after(q.x, q.right, rx);
        eh.rsz.top     = wfht_pkg::at_or_before(q.y, q.top, ry);
        eh.rsz.bottom  = wfht_pkg::at_or_after(q.y, q.bottom, ry);

        eh.crn.left    = wfht_pkg::at_or_before(q.x, q.left, cx);
        eh.crn.right   = wfht_pkg::at_or_after(q.x, q.right, cx);
        eh.crn.top     = wfht_pkg::at_or_before(q.y, q.top, cy);
        eh.crn.bottom  = wfht_pkg::at_or_after(q.y, q.bottom, cy);
    end

endmodule

/* design/wfht_grid.sv */
module wfht_grid
(
    input  wfht_pkg::side_set_t grid,
    input  logic [11:0]         m_left,
    input  logic [11:0]         m_right,
    input  logic                left_zero_chk,
    output wfht_pkg::hit_t      grid_code
);

    logic skip_left;

    assign skip_left = left_zero_chk && (m_left == 12'd0) && (m_right != 12'd0);

    always_comb
    begin
        if (!skip_left && grid.left)
        begin
            grid_code = grid.top ? wfht_pkg::HIT_TOPLEFT :
                        (grid.bottom ? wfht_pkg::HIT_BOTTOMLEFT : wfht_pkg::HIT_LEFT);
        end
        else if (grid.right)
        begin
            grid_code = grid.top ? wfht_pkg::HIT_TOPRIGHT :
                        (grid.bottom ? wfht_pkg::HIT_BOTTOMRIGHT : wfht_pkg::HIT_RIGHT);
        end
        else if (grid.top)
        begin
            grid_code = wfht_pkg::HIT_TOP;
        end
        else if (grid.bottom)
        begin
            grid_code = wfht_pkg::HIT_BOTTOM;
        end
        else
        begin
            grid_code = wfht_pkg::HIT_CLIENT;
        end
    end

endmodule

/* design/wfht_refine.sv */
module wfht_refine
(
    input  wfht_pkg::hit_t       grid_code,
    input  wfht_pkg::edge_hits_t eh,
    input  logic [6:0]           flags,
    output wfht_pkg::hit_t       hit
);

    function automatic wfht_pkg::hit_t corner_of(logic left, logic top);
        if (top)
        begin
            return left ? wfht_pkg::HIT_TOPLEFT : wfht_pkg::HIT_TOPRIGHT;
        end
        return left ? wfht_pkg::HIT_BOTTOMLEFT : wfht_pkg::HIT_BOTTOMRIGHT;
    endfunction

    // in both bands -> corner; in one band -> corner if the other axis is
    // within the corner extent, else that side; in neither band -> miss
    function automatic wfht_pkg::hit_t corner_test(logic xin, logic yin, logic xc, logic yc,
                                                   wfht_pkg::hit_t corner,
                                                   wfht_pkg::hit_t xs, wfht_pkg::hit_t ys,
                                                   wfht_pkg::hit_t miss);
        wfht_pkg::hit_t r;
        if (xin && yin)
        begin
            r = corner;
        end
        else if (xin)
        begin
            r = yc ? corner : xs;
        end
        else if (yin)
        begin
            r = xc ? corner : ys;
        end
        else
        begin
            r = miss;
        end
        return r;
    endfunction

    logic is_left;
    logic is_right;
    logic is_top;
    logic is_bottom;
    logic xr;
    logic xc;
    logic yr;
    logic yc;
    logic en_x;
    logic en_y;
    logic en_l;
    logic en_r;
    logic en_t;
    logic en_b;
    wfht_pkg::hit_t xs;
    wfht_pkg::hit_t ys;
    wfht_pkg::hit_t miss;
    wfht_pkg::hit_t r_xt;
    wfht_pkg::hit_t r_xb;
    wfht_pkg::hit_t r_yl;
    wfht_pkg::hit_t r_yr;
    wfht_pkg::hit_t r_xy;
    wfht_pkg::hit_t refined;

    always_comb
    begin
        is_left   = (grid_code == wfht_pkg::HIT_LEFT) || (grid_code == wfht_pkg::HIT_TOPLEFT) ||
                    (grid_code == wfht_pkg::HIT_BOTTOMLEFT);
        is_right  = (grid_code == wfht_pkg::HIT_RIGHT) || (grid_code == wfht_pkg::HIT_TOPRIGHT) ||
                    (grid_code == wfht_pkg::HIT_BOTTOMRIGHT);
        is_top    = (grid_code == wfht_pkg::HIT_TOP) || (grid_code == wfht_pkg::HIT_TOPLEFT) ||
                    (grid_code == wfht_pkg::HIT_TOPRIGHT);
        is_bottom = (grid_code == wfht_pkg::HIT_BOTTOM) ||
                    (grid_code == wfht_pkg::HIT_BOTTOMLEFT) ||
                    (grid_code == wfht_pkg::HIT_BOTTOMRIGHT);

        en_l = flags[wfht_pkg::FLAG_RSZ_LEFT];
        en_r = flags[wfht_pkg::FLAG_RSZ_RIGHT];
        en_t = flags[wfht_pkg::FLAG_RSZ_TOP];
        en_b = flags[wfht_pkg::FLAG_RSZ_BOTTOM];

        xr   = is_left ? eh.rsz.left : eh.rsz.right;
        xc   = is_left ? eh.crn.left : eh.crn.right;
        en_x = is_left ? en_l : en_r;
        yr   = is_top ? eh.rsz.top : eh.rsz.bottom;
        yc   = is_top ? eh.crn.top : eh.crn.bottom;
        en_y = is_top ? en_t : en_b;
        xs   = is_left ? wfht_pkg::HIT_LEFT : wfht_pkg::HIT_RIGHT;
        ys   = is_top ? wfht_pkg::HIT_TOP : wfht_pkg::HIT_BOTTOM;
        miss = (is_top && flags[wfht_pkg::FLAG_CAPTION]) ? wfht_pkg::HIT_CAPTION :
                                                           wfht_pkg::HIT_BORDER;

        r_xt = corner_test(xr, eh.rsz.top, xc, eh.crn.top, corner_of(is_left, 1'b1),
                           xs, wfht_pkg::HIT_TOP, miss);
        r_xb = corner_test(xr, eh.rsz.bottom, xc, eh.crn.bottom, corner_of(is_left, 1'b0),
                           xs, wfht_pkg::HIT_BOTTOM, miss);
        r_yl = corner_test(eh.rsz.left, yr, eh.crn.left, yc, corner_of(1'b1, is_top),
                           wfht_pkg::HIT_LEFT, ys, miss);
        r_yr = corner_test(eh.rsz.right, yr, eh.crn.right, yc, corner_of(1'b0, is_top),
                           wfht_pkg::HIT_RIGHT, ys, miss);
        r_xy = corner_test(xr, yr, xc, yc, corner_of(is_left, is_top), xs, ys, miss);

        refined = wfht_pkg::HIT_BORDER;
        if ((is_left || is_right) && (is_top || is_bottom))
        begin
            if (en_x && en_y)
            begin
                refined = r_xy;
            end
            else if (en_y)
            begin
                refined = yr ? ys : miss;
            end
            else if (en_x)
            begin
                refined = xr ? xs : miss;
            end
            else
            begin
                refined = miss;
            end
        end
        else if (is_left || is_right)
        begin
            if (!en_x)
            begin
                refined = miss;
            end
            else if (en_t && (r_xt != grid_code))
            begin
                refined = r_xt;
            end
            else if (en_b && (r_xb != grid_code))
            begin
                refined = r_xb;
            end
            else
            begin
                refined = xr ? xs : miss;
            end
        end
        else if (is_top || is_bottom)
        begin
            if (!en_y)
            begin
                refined = miss;
            end
            else if (en_l && (r_yl != grid_code))
            begin
                refined = r_yl;
            end
            else if (en_r && (r_yr != grid_code))
            begin
                refined = r_yr;
            end
            else
            begin
                refined = yr ? ys : miss;
            end
        end

        if (!eh.in_rect)
        begin
            hit = wfht_pkg::HIT_NOWHERE;
        end
        else if (grid_code == wfht_pkg::HIT_CLIENT)
        begin
            hit = wfht_pkg::HIT_CLIENT;
        end
        else if (|flags[wfht_pkg::FLAG_RSZ_BOTTOM:wfht_pkg::FLAG_RSZ_LEFT])
        begin
            hit = refined;
        end
        else if (flags[wfht_pkg::FLAG_CAPTION] || flags[wfht_pkg::FLAG_FIXED])
        begin
            hit = (is_top && flags[wfht_pkg::FLAG_CAPTION]) ? wfht_pkg::HIT_CAPTION :
                                                             wfht_pkg::HIT_BORDER;
        end
        else
        begin
            hit = grid_code;
        end
    end

endmodule

/* design/window_frame_hit_test_top.sv */
// Path: the start beat is captured in the input register, then hit_code
// and done are loaded from it into the result register.
// Throughput: one query per cycle; busy is never asserted.
// The result beat lasts one cycle and cannot be stalled.
// Reset (rst_n low, asynchronous) clears the pipeline valids and loads the
// resize margins with 10 and the corner extents with 17.
module window_frame_hit_test_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] rect_left,
    input  logic signed [15:0] rect_top,
    input  logic signed [15:0] rect_right,
    input  logic signed [15:0] rect_bottom,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic [11:0]        margin_left,
    input  logic [11:0]        margin_right,
    input  logic [11:0]        margin_top,
    input  logic [11:0]        margin_bottom,
    input  logic [6:0]         border_flags,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               done,
    output logic [3:0]         hit_code
);

    wfht_pkg::cfg_t       cfg_reg;
    wfht_pkg::query_t     query_reg;
    logic                 in_valid_reg;
    logic                 done_reg;
    wfht_pkg::hit_t       hit_code_reg;
    wfht_pkg::edge_hits_t eh;
    wfht_pkg::hit_t       grid_code;
    wfht_pkg::hit_t       hit_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resize_x <= wfht_pkg::RESIZE_MARGIN_RST;
            cfg_reg.resize_y <= wfht_pkg::RESIZE_MARGIN_RST;
            cfg_reg.corner_x <= wfht_pkg::CORNER_EXTENT_RST;
            cfg_reg.corner_y <= wfht_pkg::CORNER_EXTENT_RST;
        end
        else if (cfg_we)
        begin
            unique case (wfht_pkg::cfg_reg_t'(cfg_index))
                wfht_pkg::REG_RESIZE_X: cfg_reg.resize_x <= cfg_data;
                wfht_pkg::REG_RESIZE_Y: cfg_reg.resize_y <= cfg_data;
                wfht_pkg::REG_CORNER_X: cfg_reg.corner_x <= cfg_data;
                wfht_pkg::REG_CORNER_Y: cfg_reg.corner_y <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            query_reg.left     <= rect_left;
            query_reg.top      <= rect_top;
            query_reg.right    <= rect_right;
            query_reg.bottom   <= rect_bottom;
            query_reg.x        <= point_x;
            query_reg.y        <= point_y;
            query_reg.m_left   <= margin_left;
            query_reg.m_right  <= margin_right;
            query_reg.m_top    <= margin_top;
            query_reg.m_bottom <= margin_bottom;
            query_reg.flags    <= border_flags;
        end
        if (in_valid_reg)
        begin
            hit_code_reg <= hit_next;
        end
    end

    wfht_edges u_edges
    (
        .q   (query_reg),
        .cfg (cfg_reg),
        .eh  (eh)
    );

    wfht_grid u_grid
    (
        .grid          (eh.grid),
        .m_left        (query_reg.m_left),
        .m_right       (query_reg.m_right),
        .left_zero_chk (query_reg.flags[wfht_pkg::FLAG_LEFT_ZERO]),
        .grid_code     (grid_code)
    );

    wfht_refine u_refine
    (
        .grid_code (grid_code),
        .eh        (eh),
        .flags     (query_reg.flags),
        .hit       (hit_next)
    );

    assign done     = done_reg;
    assign hit_code = hit_code_reg;

`ifndef SYNTHESIS
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted beat gave no result");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("result beat without a query");

    a_nowhere_iff_outside: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((hit_code == wfht_pkg::HIT_NOWHERE) == !$past(eh.in_rect)))
        else $error("nowhere code does not match rectangle test");

    a_client_from_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (hit_code == wfht_pkg::HIT_CLIENT)) |->
        ($past(grid_code) == wfht_pkg::HIT_CLIENT))
        else $error("client code without client grid cell");

    a_caption_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (hit_code == wfht_pkg::HIT_CAPTION)) |->
        $past(query_reg.flags[wfht_pkg::FLAG_CAPTION]))
        else $error("caption code without caption flag");
`endif

endmodule
